>>> rtl/line_tokenizer_macros.svh
// Assertion helpers for the line tokenizer.
`ifndef LINE_TOKENIZER_MACROS_SVH
`define LINE_TOKENIZER_MACROS_SVH
`ifndef SYNTHESIS
`define LT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("line_tokenizer: check failed");
`define LT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("line_tokenizer: check failed");
`else
`define LT_ASSERT_IMP(lbl, ante, cons)
`define LT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/lt_pkg.sv
package lt_pkg;

    localparam int CHAR_W       = 8;
    localparam int POS_W        = 7;
    localparam int START_W      = 8;
    localparam int LEN_W        = 7;
    localparam int IDX_W        = 8;
    localparam int NUM_PUNCT    = 4;
    localparam int MAX_LINE_DEF = 127;
    localparam int RES_PER_ITEM = 3;
    localparam int FIFO_DEPTH   = 8;
    localparam int CFG_ADDR_W   = 3;
    localparam int MDATA_W      = 24;

    localparam logic [LEN_W-1:0]  WORD_LEN_MAX   = 7'd127;
    localparam logic [IDX_W-1:0]  MAX_TOKENS_RST = 8'd59;
    localparam logic [CHAR_W-1:0] PUNCT0_RST     = 8'd46;
    localparam logic [CHAR_W-1:0] PUNCT1_RST     = 8'd44;
    localparam logic [CHAR_W-1:0] PUNCT2_RST     = 8'd34;
    localparam logic [CHAR_W-1:0] PUNCT3_RST     = 8'd0;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MAX_TOKENS = 3'd0,
        CFG_PUNCT_0    = 3'd1,
        CFG_PUNCT_1    = 3'd2,
        CFG_PUNCT_2    = 3'd3,
        CFG_PUNCT_3    = 3'd4
    } cfg_reg_e;

    typedef enum logic {
        KIND_TOKEN = 1'b0,
        KIND_EOL   = 1'b1
    } rec_kind_e;

    typedef struct packed {
        rec_kind_e           kind;
        logic                dropped;
        logic [IDX_W-1:0]    index;
        logic [LEN_W-1:0]    length;
        logic [START_W-1:0]  start;
    } rec_t;

    // fixed separators: NUL, space, tab, newline, form feed, period, comma, question mark
    function automatic logic is_sep(input logic [CHAR_W-1:0] c);
        logic r;
        case (c)
            8'h00, 8'h20, 8'h09, 8'h0A, 8'h0C, 8'h2E, 8'h2C, 8'h3F: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/line_tokenizer.sv
// line_tokenizer: splits a text line, one character per request, into tokens.
// Input channel s_*: tdata = character, tlast = final character of the line.
// Config channel cfg_*: cfg_addr 0 = max_tokens, 1..4 = punctuation list;
//   write only while the block is idle. cfg_ready is always high.
// Result channel m_*: one request per token, then an end record (tuser = 1,
//   tlast = 1) that carries the stored token count in token_index.
// Each character is classified and the tokenizer state updated in the cycle
// it is accepted; the up to three results it causes are pushed into an
// 8-entry result queue whose head drives m_*. Results are registered in the
// queue before they reach m_*. Throughput is one character per cycle while
// the queue has room for three results; s_tready drops when fewer slots are
// free, so characters that yield several results wait for the queue to drain.
// When the receiver stalls, results wait in the queue and input is held off
// once it nears full. Synchronous active-low reset clears the line state,
// empties the queue and restores the configuration defaults.
`include "line_tokenizer_macros.svh"

module line_tokenizer #(
    parameter int MAX_LINE = lt_pkg::MAX_LINE_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lt_pkg::CHAR_W-1:0]       s_tdata,   // [7:0] character
    input  logic                            s_tlast,   // line_end
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lt_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [lt_pkg::CHAR_W-1:0]       cfg_data,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] token_start, [14:8] tok_len, [22:15] token_index, [23] dropped
    output logic [lt_pkg::MDATA_W-1:0]      m_tdata,
    output logic                            m_tuser,   // kind
    output logic                            m_tlast    // last
);

    localparam int PTR_W = $clog2(lt_pkg::FIFO_DEPTH);
    localparam int CNT_W = PTR_W + 1;
    localparam logic [lt_pkg::POS_W-1:0] LINE_LIMIT = lt_pkg::POS_W'(MAX_LINE);
    localparam logic [CNT_W-1:0] ROOM_LIMIT =
        CNT_W'(lt_pkg::FIFO_DEPTH - lt_pkg::RES_PER_ITEM);

    // configuration
    logic [lt_pkg::IDX_W-1:0]  max_tokens_reg;
    logic [lt_pkg::CHAR_W-1:0] punct_reg [lt_pkg::NUM_PUNCT];

    // line state
    logic                        in_word_reg, in_word_next;
    logic [lt_pkg::START_W-1:0]  word_start_reg, word_start_next;
    logic [lt_pkg::LEN_W-1:0]    word_len_reg, word_len_next;
    logic [lt_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [lt_pkg::IDX_W-1:0]    tok_cnt_reg, tok_cnt_next;

    // result queue
    lt_pkg::rec_t      fifo_reg [lt_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;

    logic                        s_req, m_req;
    logic                        active, hit_punct, hit_sep, word_mid;
    logic [lt_pkg::START_W-1:0]  offset;
    logic [lt_pkg::START_W-1:0]  start_mid;
    logic [lt_pkg::LEN_W-1:0]    len_mid;
    logic                        fire_w, fire_b;
    logic                        drop_w, drop_b;
    logic [lt_pkg::IDX_W-1:0]    cnt1, cnt2;
    lt_pkg::rec_t                rec_w, rec_b, rec_e;
    lt_pkg::rec_t                recs [lt_pkg::RES_PER_ITEM];
    logic [1:0]                  n_push;
    lt_pkg::rec_t                head;

    assign s_req     = s_tvalid && s_tready;
    assign m_req     = m_tvalid && m_tready;
    assign cfg_ready = 1'b1;
    assign s_tready  = (fill_reg <= ROOM_LIMIT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_tokens_reg <= lt_pkg::MAX_TOKENS_RST;
            punct_reg[0]   <= lt_pkg::PUNCT0_RST;
            punct_reg[1]   <= lt_pkg::PUNCT1_RST;
            punct_reg[2]   <= lt_pkg::PUNCT2_RST;
            punct_reg[3]   <= lt_pkg::PUNCT3_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                lt_pkg::CFG_MAX_TOKENS: max_tokens_reg <= cfg_data;
                lt_pkg::CFG_PUNCT_0:    punct_reg[0]   <= cfg_data;
                lt_pkg::CFG_PUNCT_1:    punct_reg[1]   <= cfg_data;
                lt_pkg::CFG_PUNCT_2:    punct_reg[2]   <= cfg_data;
                lt_pkg::CFG_PUNCT_3:    punct_reg[3]   <= cfg_data;
                default: ;
            endcase
        end
    end

    // classification: punctuation list ends at its first zero entry
    always_comb begin
        hit_punct = 1'b0;
        if (punct_reg[0] != '0) begin
            if (s_tdata == punct_reg[0]) hit_punct = 1'b1;
            if (punct_reg[1] != '0) begin
                if (s_tdata == punct_reg[1]) hit_punct = 1'b1;
                if (punct_reg[2] != '0) begin
                    if (s_tdata == punct_reg[2]) hit_punct = 1'b1;
                    if (punct_reg[3] != '0 && s_tdata == punct_reg[3]) hit_punct = 1'b1;
                end
            end
        end
    end

    assign hit_sep = lt_pkg::is_sep(s_tdata);
    assign active  = (pos_reg < LINE_LIMIT);
    assign offset  = lt_pkg::START_W'(pos_reg) + 1'b1;

    // word state after this character, before the line end is applied
    always_comb begin
        word_mid  = in_word_reg;
        start_mid = word_start_reg;
        len_mid   = word_len_reg;
        if (active) begin
            if (hit_punct || hit_sep) begin
                word_mid = 1'b0;
            end else if (!in_word_reg) begin
                word_mid  = 1'b1;
                start_mid = offset;
                len_mid   = lt_pkg::LEN_W'(1);
            end else if (word_len_reg < lt_pkg::WORD_LEN_MAX) begin
                len_mid = word_len_reg + 1'b1;
            end
        end
    end

    // word token closes on a separator/punctuation or at line end
    assign fire_w = (active && (hit_punct || hit_sep) && in_word_reg) ||
                    (s_tlast && word_mid);
    assign fire_b = active && hit_punct;

    assign drop_w = (tok_cnt_reg >= max_tokens_reg);
    assign cnt1   = (fire_w && !drop_w) ? tok_cnt_reg + 1'b1 : tok_cnt_reg;
    assign drop_b = (cnt1 >= max_tokens_reg);
    assign cnt2   = (fire_b && !drop_b) ? cnt1 + 1'b1 : cnt1;

    always_comb begin
        rec_w.kind    = lt_pkg::KIND_TOKEN;
        rec_w.dropped = drop_w;
        rec_w.index   = tok_cnt_reg;
        rec_w.length  = fire_b || !s_tlast || (active && (hit_punct || hit_sep)) ?
                        word_len_reg : len_mid;
        rec_w.start   = (active && (hit_punct || hit_sep)) ? word_start_reg : start_mid;
        rec_b.kind    = lt_pkg::KIND_TOKEN;
        rec_b.dropped = drop_b;
        rec_b.index   = cnt1;
        rec_b.length  = lt_pkg::LEN_W'(1);
        rec_b.start   = offset;
        rec_e.kind    = lt_pkg::KIND_EOL;
        rec_e.dropped = 1'b0;
        rec_e.index   = cnt2;
        rec_e.length  = '0;
        rec_e.start   = '0;
    end

    // compact the results of this character into consecutive slots
    always_comb begin
        recs[0] = rec_e;
        recs[1] = rec_e;
        recs[2] = rec_e;
        n_push  = 2'd0;
        if (s_req) begin
            if (fire_w) begin
                recs[n_push] = rec_w;
                n_push       = n_push + 1'b1;
            end
            if (fire_b) begin
                recs[n_push] = rec_b;
                n_push       = n_push + 1'b1;
            end
            if (s_tlast) begin
                recs[n_push] = rec_e;
                n_push       = n_push + 1'b1;
            end
        end
    end

    always_comb begin
        in_word_next    = in_word_reg;
        word_start_next = word_start_reg;
        word_len_next   = word_len_reg;
        pos_next        = pos_reg;
        tok_cnt_next    = tok_cnt_reg;
        if (s_req) begin
            word_start_next = start_mid;
            if (s_tlast) begin
                in_word_next  = 1'b0;
                word_len_next = '0;
                pos_next      = '0;
                tok_cnt_next  = '0;
            end else begin
                in_word_next  = word_mid;
                word_len_next = len_mid;
                tok_cnt_next  = cnt2;
                if (active) pos_next = offset[lt_pkg::POS_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_word_reg  <= 1'b0;
            word_len_reg <= '0;
            pos_reg      <= '0;
            tok_cnt_reg  <= '0;
        end else begin
            in_word_reg  <= in_word_next;
            word_len_reg <= word_len_next;
            pos_reg      <= pos_next;
            tok_cnt_reg  <= tok_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_start_reg <= '0;
        end else begin
            word_start_reg <= word_start_next;
        end
    end

    // result queue
    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(n_push);
        rd_ptr_next = m_req ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + CNT_W'(n_push) - CNT_W'(m_req);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < lt_pkg::RES_PER_ITEM; i++) begin
            if (i < int'(n_push)) begin
                fifo_reg[wr_ptr_reg + PTR_W'(i)] <= recs[i];
            end
        end
    end

    assign head     = fifo_reg[rd_ptr_reg];
    assign m_tvalid = (fill_reg != '0);
    assign m_tdata  = {head.dropped, head.index, head.length, head.start};
    assign m_tuser  = head.kind;
    assign m_tlast  = (head.kind == lt_pkg::KIND_EOL);

    `LT_ASSERT_IMP(a_fill_bound, 1'b1, fill_reg <= CNT_W'(lt_pkg::FIFO_DEPTH))
    `LT_ASSERT_NEXT(a_eol_clears, s_req && s_tlast, pos_reg == '0 && tok_cnt_reg == '0 && !in_word_reg)
    `LT_ASSERT_IMP(a_token_len, m_tvalid && !m_tuser, m_tdata[14:8] != '0 && m_tdata[7:0] != '0)
    `LT_ASSERT_IMP(a_no_overfill, s_req, fill_reg <= ROOM_LIMIT)

endmodule
